### hw/rtl/ptvc_pkg.sv
// Shared types and constants for the road-tube vehicle counter.
package ptvc_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned BASE_W    = 19;
  localparam int unsigned LEVEL_W   = BASE_W - FRAC_BITS;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TDATA_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_OFF   = 2'd2;

  localparam logic [COUNT_W-1:0]  CAL_SAMPLES_RST = 16'd5000;
  localparam logic [SAMPLE_W-1:0] RISE_THRESH_RST = 10'd5;
  localparam logic [SAMPLE_W-1:0] REARM_OFF_RST   = 10'd10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] SEEN_MAX  = '1;

  // Truncating divide by 10 and 100 of a 19-bit magnitude: (x * MULT) >> SHIFT
  localparam int unsigned       RECIP_W      = 20;
  localparam logic [RECIP_W-1:0] DIV10_MULT   = 20'd838861;
  localparam int unsigned       DIV10_SHIFT  = 23;
  localparam logic [RECIP_W-1:0] DIV100_MULT  = 20'd671089;
  localparam int unsigned       DIV100_SHIFT = 26;

  // Input request kinds (tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CREDIT = 1'b1;

  // Result tdata bit positions
  localparam int unsigned OUT_HIT_BIT   = 16;
  localparam int unsigned OUT_ADDED_BIT = 17;
  localparam int unsigned OUT_CAL_BIT   = 18;

  typedef struct packed {
    logic [COUNT_W-1:0]  cal_samples;
    logic [SAMPLE_W-1:0] rise_thresh;
    logic [SAMPLE_W-1:0] rearm_off;
  } cfg_t;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline;
    logic               axle_phase;
    logic [COUNT_W-1:0] vehicle_total;
    logic [COUNT_W-1:0] samples_seen;
  } state_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic                ack_ok;
    logic [COUNT_W-1:0]  returned_count;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] vehicle_count;
    logic               axle_hit;
    logic               vehicle_added;
    logic               calibrating;
    logic [LEVEL_W-1:0] baseline_level;
  } result_t;

endpackage

### hw/rtl/ptvc_step.sv
// Per-request update: baseline tracking, axle detection, count and credit.
module ptvc_step (
  input  ptvc_pkg::cfg_t    cfg,
  input  ptvc_pkg::state_t  st,
  input  ptvc_pkg::item_t   item,
  output ptvc_pkg::state_t  st_next,
  output ptvc_pkg::result_t res
);
  import ptvc_pkg::*;

  logic                        cal;
  logic [BASE_W:0]             samp_fix;
  logic [BASE_W:0]             diff;
  logic                        diff_neg;
  logic [BASE_W-1:0]           mag;
  logic [RECIP_W-1:0]          recip;
  logic [BASE_W+RECIP_W-1:0]   prod;
  logic [BASE_W-1:0]           quot;
  logic [BASE_W-1:0]           tracked;
  logic [BASE_W:0]             hit_level;
  logic                        hit;
  logic [LEVEL_W-1:0]          rearm_int;
  logic [BASE_W-1:0]           rearm_base;

  assign cal      = st.samples_seen < cfg.cal_samples;
  assign samp_fix = {{(BASE_W+1-SAMPLE_W-FRAC_BITS){1'b0}}, item.sample, {FRAC_BITS{1'b0}}};
  assign diff     = samp_fix - {1'b0, st.baseline};
  assign diff_neg = diff[BASE_W];
  assign mag      = diff_neg ? BASE_W'(-diff) : diff[BASE_W-1:0];

  // One shared reciprocal multiply serves both divisors
  assign recip = cal ? DIV10_MULT : DIV100_MULT;
  assign prod  = mag * recip;
  assign quot  = cal ? BASE_W'(prod >> DIV10_SHIFT) : BASE_W'(prod >> DIV100_SHIFT);
  assign tracked = diff_neg ? (st.baseline - quot) : (st.baseline + quot);

  assign hit_level = {1'b0, st.baseline}
                   + {{(BASE_W+1-SAMPLE_W-FRAC_BITS){1'b0}}, cfg.rise_thresh,
                      {FRAC_BITS{1'b0}}};
  assign hit       = (item.op == OP_SAMPLE) && !cal && (samp_fix > hit_level);

  assign rearm_int  = LEVEL_W'(item.sample) + LEVEL_W'(cfg.rearm_off);
  assign rearm_base = {rearm_int, {FRAC_BITS{1'b0}}};

  always_comb begin
    st_next = st;
    res.axle_hit      = 1'b0;
    res.vehicle_added = 1'b0;
    if (item.op == OP_SAMPLE) begin
      if (hit) begin
        res.axle_hit       = 1'b1;
        st_next.axle_phase = ~st.axle_phase;
        st_next.baseline   = rearm_base;
        // phase returns to one on every second axle
        if (!st.axle_phase) begin
          res.vehicle_added = 1'b1;
          if (st.vehicle_total != COUNT_MAX) begin
            st_next.vehicle_total = st.vehicle_total + 1'b1;
          end
        end
      end else begin
        st_next.baseline = tracked;
      end
      if (st.samples_seen != SEEN_MAX) begin
        st_next.samples_seen = st.samples_seen + 1'b1;
      end
    end else if (item.ack_ok) begin
      // clamp credit at zero
      st_next.vehicle_total = (st.vehicle_total > item.returned_count) ?
                              st.vehicle_total - item.returned_count : '0;
    end
    res.vehicle_count  = st_next.vehicle_total;
    res.calibrating    = cal;
    res.baseline_level = st_next.baseline[BASE_W-1:FRAC_BITS];
  end

endmodule

### hw/rtl/pressure_tube_vehicle_counter.sv
// Flow: an accepted request waits in the input register until the result register is
//   empty or its result is taken. Throughput is one request per cycle unless the
//   output stalls; the path from the input register through the shared
//   divide-by-constant multiply into the baseline register sets the clock.
// A stalled result holds in the result register while the input register still fills.
// Reset (rst, synchronous) clears both valids and the state: baseline 0, phase 1,
//   count 0, samples seen 0, and loads the register defaults 5000, 5 and 10.
module pressure_tube_vehicle_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] sample, [10] ack_ok, [26:11] returned_count, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] vehicle_count, [16] axle_hit, [17] vehicle_added, [18] calibrating,
  // [29:19] baseline_level, [31:30] zero
  output logic [31:0] m_axis_tdata
);
  import ptvc_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  logic    item_vld;
  result_t res_next;
  result_t res;
  logic    res_vld;
  logic    advance;

  assign advance       = item_vld && (!res_vld || m_axis_tready);
  assign s_axis_tready = !item_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_samples <= CAL_SAMPLES_RST;
      cfg.rise_thresh <= RISE_THRESH_RST;
      cfg.rearm_off   <= REARM_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_SAMPLES: cfg.cal_samples <= cfg_data[COUNT_W-1:0];
        REG_RISE_THRESH: cfg.rise_thresh <= cfg_data[SAMPLE_W-1:0];
        REG_REARM_OFF:   cfg.rearm_off   <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.op             <= s_axis_tuser[0];
      item.sample         <= s_axis_tdata[9:0];
      item.ack_ok         <= s_axis_tdata[10];
      item.returned_count <= s_axis_tdata[26:11];
    end
  end

  ptvc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // State and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      st.baseline      <= '0;
      st.axle_phase    <= 1'b1;
      st.vehicle_total <= '0;
      st.samples_seen  <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (m_axis_tready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_vld;
  assign m_axis_tdata  = {2'b00, res.baseline_level, res.calibrating, res.vehicle_added,
                          res.axle_hit, res.vehicle_count};

endmodule

### hw/rtl/ptvc_checker.sv
// Port-level checks for the road-tube vehicle counter, bound to the top level.
module ptvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import ptvc_pkg::*;

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_ADDED_BIT] |-> m_axis_tdata[OUT_HIT_BIT])
    else $error("vehicle added without an axle");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_HIT_BIT] |-> !m_axis_tdata[OUT_CAL_BIT])
    else $error("axle reported during calibration");

endmodule

bind pressure_tube_vehicle_counter ptvc_checker u_ptvc_checker (.*);

### bench/axle_count_checker.sv
// Checker that predicts and scores every result of the road-tube vehicle counter.
module axle_count_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ptvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptvc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // [9:0] sample, [10] ack_ok, [26:11] returned_count, [31:27] zero
  input  logic [ptvc_pkg::TDATA_W-1:0]    s_tdata,
  // [0] op
  input  logic [0:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] vehicle_count, [16] axle_hit, [17] vehicle_added, [18] calibrating,
  // [29:19] baseline_level, [31:30] zero
  input  logic [ptvc_pkg::TDATA_W-1:0]    m_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output logic [ptvc_pkg::LEVEL_W-1:0]    level_hint
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptvc_pkg::*;

  localparam int CAL_DIV   = 10;
  localparam int TRACK_DIV = 100;
  localparam int SHOW_MAX  = 40;

  // Shadow registers and state of the counter
  logic [COUNT_W-1:0]  cal_len;
  logic [SAMPLE_W-1:0] rise;
  logic [SAMPLE_W-1:0] rearm;
  logic [BASE_W-1:0]   base;
  logic                phase;
  logic [COUNT_W-1:0]  total;
  logic [COUNT_W-1:0]  seen;

  result_t tally_q[$];
  int      errors = 0;
  int      n_checked = 0;

  // Move the baseline toward the sample by diff/divisor, truncated toward zero.
  function automatic logic [BASE_W-1:0] glide(logic [BASE_W-1:0] from,
                                              logic [SAMPLE_W-1:0] smp, int divisor);
    int target;
    int diff;
    target = int'(smp) << FRAC_BITS;
    diff   = target - int'(from);
    return BASE_W'(int'(from) + diff / divisor);
  endfunction

  function automatic result_t advance_counter(logic op, logic [SAMPLE_W-1:0] smp,
                                              logic ack, logic [COUNT_W-1:0] ret);
    result_t     r;
    logic [31:0] smp_fix;
    logic [31:0] trip_fix;
    r = '0;
    r.calibrating = (seen < cal_len);
    if (op == OP_SAMPLE) begin
      smp_fix  = 32'(smp) << FRAC_BITS;
      trip_fix = 32'(base) + (32'(rise) << FRAC_BITS);
      if (r.calibrating) begin
        base = glide(base, smp, CAL_DIV);
      end else if (smp_fix > trip_fix) begin
        r.axle_hit = 1'b1;
        phase = ~phase;
        if (phase) begin
          r.vehicle_added = 1'b1;
          if (total != COUNT_MAX) total = total + 1'b1;
        end
        base = BASE_W'((32'(smp) + 32'(rearm)) << FRAC_BITS);
      end else begin
        base = glide(base, smp, TRACK_DIV);
      end
      if (seen != SEEN_MAX) seen = seen + 1'b1;
    end else if (ack) begin
      total = (total > ret) ? total - ret : '0;
    end
    r.vehicle_count  = total;
    r.baseline_level = base[BASE_W-1:FRAC_BITS];
    return r;
  endfunction

  task automatic score(string what, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= SHOW_MAX)
        $display("at %0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      cal_len = CAL_SAMPLES_RST;
      rise    = RISE_THRESH_RST;
      rearm   = REARM_OFF_RST;
      base    = '0;
      phase   = 1'b1;
      total   = '0;
      seen    = '0;
      tally_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_SAMPLES: cal_len = cfg_data;
          REG_RISE_THRESH: rise    = cfg_data[SAMPLE_W-1:0];
          REG_REARM_OFF:   rearm   = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.vehicle_count  = m_tdata[COUNT_W-1:0];
        got.axle_hit       = m_tdata[OUT_HIT_BIT];
        got.vehicle_added  = m_tdata[OUT_ADDED_BIT];
        got.calibrating    = m_tdata[OUT_CAL_BIT];
        got.baseline_level = m_tdata[OUT_CAL_BIT+1 +: LEVEL_W];
        if (tally_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("at %0t: stray result, expected none, got tdata %h", $time, m_tdata);
        end else begin
          want = tally_q.pop_front();
          n_checked++;
          score("vehicle_count", want.vehicle_count, got.vehicle_count);
          score("axle_hit", want.axle_hit, got.axle_hit);
          score("vehicle_added", want.vehicle_added, got.vehicle_added);
          score("calibrating", want.calibrating, got.calibrating);
          score("baseline_level", want.baseline_level, got.baseline_level);
        end
      end
      if (s_tvalid && s_tready)
        tally_q.push_back(advance_counter(s_tuser[0], s_tdata[SAMPLE_W-1:0],
                                          s_tdata[SAMPLE_W],
                                          s_tdata[SAMPLE_W+1 +: COUNT_W]));
    end
    pending    <= tally_q.size();
    fail_count <= errors;
    checked    <= n_checked;
    level_hint <= base[BASE_W-1:FRAC_BITS];
  end

endmodule

### bench/pressure_tube_vehicle_counter_tb.sv
// Stimulus and verdict for the road-tube vehicle counter, scored by axle_count_checker.
module pressure_tube_vehicle_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptvc_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int MAX_GAP      = 13;
  localparam int BURST_PAIRS  = 40;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 80;
  localparam int SAMPLE_MAX   = 2**SAMPLE_W - 1;
  localparam int CFG_MAX      = 2**COUNT_W - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;

  int                 fail_count;
  int                 pending;
  int                 checked;
  logic [LEVEL_W-1:0] level_hint;

  bit steady  = 1'b0;
  bit no_gaps = 1'b0;
  int samples_sent = 0;
  int settings = 0;
  int ready_wait = 0;

  pressure_tube_vehicle_counter DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  axle_count_checker tally_watch (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .level_hint (level_hint)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a random stall per taken result (none if steady or no_gaps), ready held low.
  always @(posedge clk) begin : stall_source
    int g;
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_wait    <= 0;
    end else if (!m_axis_tready) begin
      if (ready_wait <= 1) m_axis_tready <= 1'b1;
      else ready_wait <= ready_wait - 1;
    end else if (m_axis_tvalid) begin
      g = (steady || no_gaps) ? 0 : $urandom_range(0, MAX_GAP);
      if (g != 0) begin
        m_axis_tready <= 1'b0;
        ready_wait    <= g;
      end
    end
  end

  task automatic push_request(logic op, logic [SAMPLE_W-1:0] smp, logic ack,
                              logic [COUNT_W-1:0] ret);
    int gap;
    if (!steady && $urandom_range(0, 29) == 0) no_gaps = ~no_gaps;
    gap = (steady || no_gaps) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, ret, ack, smp};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_SAMPLE && samples_sent < CFG_MAX) samples_sent++;
  endtask

  // Unused fields carry random bits.
  task automatic put_sample(logic [SAMPLE_W-1:0] smp);
    push_request(OP_SAMPLE, smp, 1'($urandom_range(0, 1)), 16'($urandom_range(0, CFG_MAX)));
  endtask

  task automatic put_credit(logic ack, logic [COUNT_W-1:0] ret);
    push_request(OP_CREDIT, 10'($urandom_range(0, SAMPLE_MAX)), ack, ret);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(int unsigned cal, int unsigned thr, int unsigned rearm);
    drain();
    write_reg(REG_CAL_SAMPLES, cal);
    write_reg(REG_RISE_THRESH, thr);
    write_reg(REG_REARM_OFF, rearm);
    settings++;
  endtask

  function automatic int unsigned pick_level(int unsigned top, int unsigned near);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      2:       return $urandom_range(0, top);
      default: return $urandom_range(0, near);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned cal;
    int unsigned thr;
    int unsigned rearm;
    int          roll;
    int          aim;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: long calibration window
    put_sample(10'(SAMPLE_MAX));
    put_credit(1'b1, 16'd5);
    drain();
    write_reg(REG_CAL_SAMPLES, 2);
    settings++;
    put_sample(10'd0);
    put_sample(10'(SAMPLE_MAX));
    put_sample(10'(SAMPLE_MAX));
    drain();
    write_reg(REG_RISE_THRESH, 0);
    write_reg(REG_REARM_OFF, 0);
    write_reg(REG_SPARE, 16'hFFFF);
    settings++;
    // Pulse/floor: every pulse but the first is an axle, every second axle a vehicle
    repeat (3) begin
      put_sample(10'(SAMPLE_MAX));
      put_sample(10'd0);
    end
    put_sample(10'(SAMPLE_MAX));
    put_credit(1'b0, 16'd0);
    put_credit(1'b1, 16'd1);
    put_credit(1'b1, 16'hFFFF);
    put_sample(10'd512);
    drain();
    write_reg(REG_RISE_THRESH, SAMPLE_MAX);
    write_reg(REG_REARM_OFF, SAMPLE_MAX);
    settings++;
    put_sample(10'(SAMPLE_MAX));
    put_sample(10'd0);
    drain();
    write_reg(REG_RISE_THRESH, 0);
    settings++;
    put_sample(10'(SAMPLE_MAX));
    put_sample(10'(SAMPLE_MAX));
    drain();
    write_reg(REG_CAL_SAMPLES, CFG_MAX);
    settings++;
    put_sample(10'(SAMPLE_MAX));
    put_sample(10'd0);
    drain();
    write_reg(REG_CAL_SAMPLES, 0);
    settings++;
    put_sample(10'(SAMPLE_MAX));

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       cal = 0;
        1:       cal = CFG_MAX;
        default: begin
          cal = samples_sent + $urandom_range(0, 40);
          if (cal > CFG_MAX) cal = CFG_MAX;
        end
      endcase
      thr   = pick_level(SAMPLE_MAX, 24);
      rearm = pick_level(SAMPLE_MAX, 24);
      program_regs(cal, thr, rearm);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          put_credit(1'($urandom_range(0, 3) != 0),
                     ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom));
        end else if (roll < 65) begin
          // Aim just around the trip point of the current baseline
          aim = int'(level_hint) + int'(thr) + int'($urandom_range(0, 10)) - 3;
          if (aim < 0) aim = 0;
          if (aim > SAMPLE_MAX) aim = SAMPLE_MAX;
          put_sample(10'(aim));
        end else if (roll < 85) begin
          put_sample(10'($urandom_range(0, 64)));
        end else begin
          put_sample(10'($urandom));
        end
      end
    end

    // Back-to-back axle pairs with no stalls on either side
    program_regs(0, 0, 0);
    put_credit(1'b1, 16'hFFFF);
    steady = 1'b1;
    repeat (BURST_PAIRS) begin
      put_sample(10'(SAMPLE_MAX));
      put_sample(10'd0);
    end
    steady = 1'b0;
    put_credit(1'b1, 16'd1);
    put_credit(1'b0, 16'd1);
    put_credit(1'b1, 16'hFFFF);
    program_regs(CFG_MAX, SAMPLE_MAX, SAMPLE_MAX);
    put_sample(10'(SAMPLE_MAX));
    put_sample(10'd0);

    drain();
    $display("Checked %0d results across %0d register settings.", checked, settings);
    $display("Run covered calibration, axle pairing, credit clamping and unstalled bursts.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("Timed out with %0d results outstanding.", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
